@@ hdl/ip_ban_table_with_aging_top_defines.svh @@
// Assertion macros shared by the ban table RTL.
`ifndef IP_BAN_TABLE_WITH_AGING_TOP_DEFINES_SVH
`define IP_BAN_TABLE_WITH_AGING_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define IBT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define IBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ibt_pkg.sv @@
// Shared types and constants of the IPv4 ban table.
`default_nettype none
package ibt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int FLAG_BITS = 8;
  localparam int ADDR_W = 32;
  localparam int TIME_W = 32;
  localparam int REMOVED_W = 9;
  localparam logic [TIME_W-1:0] DROP_PERIOD_RESET = TIME_W'(7 * 24 * 3600);

  typedef logic [1:0] op_t;
  localparam op_t OP_ADD     = 2'd0;
  localparam op_t OP_CHECK   = 2'd1;
  localparam op_t OP_CLEANUP = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic [FLAG_BITS-1:0] flags;
    logic [TIME_W-1:0]    seen_at;
  } ibt_entry_t;

  localparam int ENTRY_W = $bits(ibt_entry_t);

  typedef struct packed {
    op_t                  op;
    logic [ADDR_W-1:0]    addr;
    logic [FLAG_BITS-1:0] flags;
    logic [TIME_W-1:0]    now;
    logic                 upper_available;
    logic                 upper_banned;
  } ibt_req_t;

  typedef struct packed {
    logic                 okay;
    logic                 is_new;
    logic                 full;
    logic [REMOVED_W-1:0] removed;
  } ibt_res_t;

endpackage
`default_nettype wire

@@ hdl/ibt_in_if.sv @@
// Input item channel of the ban table.
`default_nettype none
interface ibt_in_if import ibt_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               operation;
  logic [ADDR_W-1:0] ip_address;
  logic [7:0]        reason_flags;
  logic [TIME_W-1:0] now_seconds;
  logic              upper_available;
  logic              upper_banned;

  modport source (output valid, operation, ip_address, reason_flags, now_seconds,
                  upper_available, upper_banned, input ready);
  modport sink   (input valid, operation, ip_address, reason_flags, now_seconds,
                  upper_available, upper_banned, output ready);
endinterface
`default_nettype wire

@@ hdl/ibt_out_if.sv @@
// Result item channel of the ban table.
`default_nettype none
interface ibt_out_if import ibt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 address_okay;
  logic                 entry_was_new;
  logic                 table_full;
  logic [REMOVED_W-1:0] removed_count;

  modport source (output valid, address_okay, entry_was_new, table_full, removed_count,
                  input ready);
  modport sink   (input valid, address_okay, entry_was_new, table_full, removed_count,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/ibt_cfg_if.sv @@
// Configuration write channel of the ban table.
`default_nettype none
interface ibt_cfg_if import ibt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hdl/ibt_ram.sv @@
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none
module ibt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/ibt_scan.sv @@
// Table scan engine: valid bits, entry memory walk, add/check/cleanup.
`default_nettype none
`include "ip_ban_table_with_aging_top_defines.svh"
module ibt_scan import ibt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire ibt_req_t          req,
  input  wire logic [TIME_W-1:0] drop_period,
  output logic                   ready,
  output logic                   res_valid,
  input  wire logic              res_take,
  output ibt_res_t               res
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t               state;
  op_t                  op;
  logic [ADDR_W-1:0]    addr;
  logic [FLAG_BITS-1:0] flags;
  logic [TIME_W-1:0]    now;
  logic [IDX_W:0]       idx;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_vld;
  logic                 free_found;
  logic [IDX_W-1:0]     free_slot;
  logic [REMOVED_W-1:0] removed;
  logic [TABLE_DEPTH-1:0] valid;

  ibt_entry_t           rd_data;
  ibt_entry_t           wr_data;
  logic                 issue;
  logic                 eval;
  logic                 cur_valid;
  logic                 hit;
  logic                 aged;
  logic                 last;
  logic                 finish;
  logic                 free_here;
  logic                 ins_ok;
  logic [IDX_W-1:0]     ins_slot;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [TIME_W:0]      expiry;

  ibt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (wr_data),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    issue     = (state == S_SCAN) && !idx[IDX_W];
    eval      = (state == S_SCAN) && rd_vld;
    cur_valid = valid[rd_idx];
    expiry    = {1'b0, rd_data.seen_at} + {1'b0, drop_period};
    hit       = eval && cur_valid && (rd_data.addr == addr);
    aged      = eval && cur_valid && (expiry < {1'b0, now});
    last      = eval && (rd_idx == IDX_W'(TABLE_DEPTH - 1));
    finish    = last || (hit && (op != OP_CLEANUP));
    free_here = eval && !cur_valid;
    ins_ok    = free_found || free_here;
    ins_slot  = free_found ? free_slot : rd_idx;
    mem_we    = (op == OP_ADD) && (hit || (finish && ins_ok));
    mem_wa    = hit ? rd_idx : ins_slot;
    wr_data.addr    = addr;
    wr_data.flags   = hit ? (rd_data.flags | flags) : flags;
    wr_data.seen_at = now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
      valid  <= '0;
    end else begin
      rd_vld <= issue;
      rd_idx <= idx[IDX_W-1:0];
      if (issue) begin
        idx <= idx + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op         <= req.op;
            addr       <= req.addr;
            flags      <= req.flags;
            now        <= req.now;
            idx        <= '0;
            free_found <= 1'b0;
            removed    <= '0;
            case (req.op)
              OP_ADD, OP_CLEANUP: begin
                res   <= '0;
                state <= S_SCAN;
              end
              OP_CHECK: begin
                if (req.upper_available) begin
                  res   <= {!req.upper_banned, 1'b0, 1'b0, {REMOVED_W{1'b0}}};
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_SCAN;
                end
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (free_here && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= rd_idx;
          end
          if ((op == OP_CLEANUP) && aged) begin
            valid[rd_idx] <= 1'b0;
            removed       <= removed + 1'b1;
          end
          if (finish) begin
            state <= S_DONE;
            case (op)
              OP_ADD: begin
                if (!hit) begin
                  if (ins_ok) begin
                    valid[ins_slot] <= 1'b1;
                    res.is_new      <= 1'b1;
                  end else begin
                    res.full <= 1'b1;
                  end
                end
              end
              OP_CHECK: begin
                res.okay <= !hit;
              end
              default: begin
                res.removed <= removed + REMOVED_W'(aged);
              end
            endcase
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  `IBT_ASSERT_NEXT(a_read_returns, issue, rd_vld, "read data not flagged after issue")
  `IBT_ASSERT_IMPL(a_write_add_only, mem_we, (state == S_SCAN) && (op == OP_ADD),
                   "entry memory written outside an add scan")
  `IBT_ASSERT_IMPL(a_count_cleanup_only, res_valid && (op != OP_CLEANUP),
                   res.removed == '0, "removed count set for a non-cleanup item")
  `IBT_ASSERT_IMPL(a_add_outcome, res_valid && (op == OP_ADD), !(res.is_new && res.full),
                   "add reported both new entry and full table")

endmodule
`default_nettype wire

@@ hdl/ip_ban_table_with_aging_top.sv @@
// Top level of the IPv4 ban table with aging.
//
// Channels: in_item takes one transaction per item (add, check or cleanup);
// out_result gives exactly one transaction per item; cfg writes drop_period
// and is always ready, to be used only while the block is idle.
// Walk: a check with an upper layer verdict, or an unused code, skips the
// entry memory and goes straight to the done state. A check or add reads the
// entry memory one entry per cycle; a hit on entry k ends the walk, a miss
// walks the whole table; a cleanup always walks the full table.
// The single read port of the entry memory sets this pace. Items are handled
// one at a time: the next item is accepted in the cycle after the result
// leaves the scan engine.
// Reset: synchronous, active high; clears all valid bits (the table is
// empty), restores drop_period to one week, drops any pending result.
// Stall: a finished result sits in the output register; the next item is
// still accepted and scanned, then its result holds in the scan engine and
// the input stalls until the register frees.
`default_nettype none
module ip_ban_table_with_aging_top import ibt_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  ibt_in_if.sink    in_item,
  ibt_out_if.source out_result,
  ibt_cfg_if.sink   cfg
);

  logic [TIME_W-1:0] drop_period;
  logic              start;
  logic              res_valid;
  logic              res_take;
  logic              out_valid;
  ibt_req_t          req;
  ibt_res_t          res;

  // Configuration register: accept every write.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_period <= DROP_PERIOD_RESET;
    end else if (cfg.valid) begin
      drop_period <= cfg.data;
    end
  end

  // Pack the accepted transaction for the scan engine.
  assign start = in_item.valid && in_item.ready;

  always_comb begin
    req.op              = in_item.operation;
    req.addr            = in_item.ip_address;
    req.flags           = in_item.reason_flags[FLAG_BITS-1:0];
    req.now             = in_item.now_seconds;
    req.upper_available = in_item.upper_available;
    req.upper_banned    = in_item.upper_banned;
  end

  ibt_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req         (req),
    .drop_period (drop_period),
    .ready       (in_item.ready),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  // Output register: load when empty or being drained this cycle.
  assign res_take = res_valid && (!out_valid || out_result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_result.address_okay  <= res.okay;
      out_result.entry_was_new <= res.is_new;
      out_result.table_full    <= res.full;
      out_result.removed_count <= res.removed;
    end
  end

  assign out_result.valid = out_valid;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the IPv4 ban table with aging.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ibt_pkg::*;

  // Operation code the block leaves unused; it must answer with all zeros.
  localparam op_t OP_UNUSED = 2'd3;

  logic clk;
  logic rst;

  ibt_in_if  in_bus ();
  ibt_out_if out_bus ();
  ibt_cfg_if cfg_bus ();

  ip_ban_table_with_aging_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_bus),
    .out_result (out_bus),
    .cfg        (cfg_bus)
  );

  // Shadow copy of the ban table and its aging register.
  logic                 ban_valid [TABLE_DEPTH];
  logic [ADDR_W-1:0]    ban_addr  [TABLE_DEPTH];
  logic [FLAG_BITS-1:0] ban_flags [TABLE_DEPTH];
  logic [TIME_W-1:0]    ban_seen  [TABLE_DEPTH];
  logic [TIME_W-1:0]    drop_period_model;

  // Outcomes of accepted transactions, oldest first.
  ibt_res_t outcome_q [$];

  int unsigned       fail_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       stall_left = 0;
  logic [TIME_W-1:0] clock_now = 32'd1000;

  // Free-running clock, 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  // Return the slot holding addr, or -1 when the address is not banned.
  function automatic int find_entry(input logic [ADDR_W-1:0] addr);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (ban_valid[i] && ban_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // Return the lowest free slot, or -1 when the table is full.
  function automatic int find_free_slot();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!ban_valid[i]) return i;
    end
    return -1;
  endfunction

  // Apply one transaction to the shadow table and return the result it yields.
  function automatic ibt_res_t apply_to_table(input ibt_req_t item);
    ibt_res_t          res;
    int                slot;
    logic [TIME_W:0]   expiry;
    res = '0;
    case (item.op)
      OP_ADD: begin
        slot = find_entry(item.addr);
        if (slot >= 0) begin
          // Refresh: move last-seen to now and accumulate the reasons.
          ban_seen[slot]  = item.now;
          ban_flags[slot] = ban_flags[slot] | item.flags;
        end else begin
          slot = find_free_slot();
          if (slot >= 0) begin
            ban_valid[slot] = 1'b1;
            ban_addr[slot]  = item.addr;
            ban_flags[slot] = item.flags;
            ban_seen[slot]  = item.now;
            res.is_new      = 1'b1;
          end else begin
            res.full = 1'b1;
          end
        end
      end
      OP_CHECK: begin
        // An upper layer verdict overrides the table lookup.
        if (item.upper_available) res.okay = !item.upper_banned;
        else                      res.okay = (find_entry(item.addr) < 0);
      end
      OP_CLEANUP: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          // Form the expiry one bit wider so it cannot wrap.
          expiry = {1'b0, ban_seen[i]} + {1'b0, drop_period_model};
          if (ban_valid[i] && expiry < {1'b0, item.now}) begin
            ban_valid[i] = 1'b0;
            res.removed  = res.removed + 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic ibt_req_t make_item(input op_t op, input logic [ADDR_W-1:0] addr,
                                         input logic [FLAG_BITS-1:0] flags,
                                         input logic [TIME_W-1:0] now,
                                         input logic ua, input logic ub);
    ibt_req_t item;
    item.op              = op;
    item.addr            = addr;
    item.flags           = flags;
    item.now             = now;
    item.upper_available = ua;
    item.upper_banned    = ub;
    return item;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until accepted, and log its outcome.
  // Valid stays high after acceptance so back-to-back items need no gap;
  // callers lower it through wait_idle before any pause.
  task automatic send_item(input ibt_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.operation       <= item.op;
    in_bus.ip_address      <= item.addr;
    in_bus.reason_flags    <= item.flags;
    in_bus.now_seconds     <= item.now;
    in_bus.upper_available <= item.upper_available;
    in_bus.upper_banned    <= item.upper_banned;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    outcome_q.insert(outcome_q.size(), apply_to_table(item));
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // Write drop_period; only called while the block is idle.
  task automatic write_drop_period(input logic [TIME_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    drop_period_model = value;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // Result receiver: random ready, or a long hold-off when stall_left is loaded.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare every accepted result against the oldest outstanding outcome.
  always @(posedge clk) begin : result_check
    ibt_res_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (outcome_q.size() == 0) begin
        $error("result transaction with no item outstanding");
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("address_okay",  32'(want.okay),    32'(out_bus.address_okay));
        check_field("entry_was_new", 32'(want.is_new),  32'(out_bus.entry_was_new));
        check_field("table_full",    32'(want.full),    32'(out_bus.table_full));
        check_field("removed_count", 32'(want.removed), 32'(out_bus.removed_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every operation, refresh, verdict override, wide aging.
  task automatic test_directed();
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, 32'h0, 1'b0, 1'b0));  // empty table
    send_item(make_item(OP_ADD, 32'h0, 8'h00, 32'h0, 1'b0, 1'b0));
    send_item(make_item(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    // Refresh the same address twice; reasons must accumulate.
    send_item(make_item(OP_ADD, 32'h0, 8'h55, 32'd10, 1'b0, 1'b0));
    send_item(make_item(OP_ADD, 32'h0, 8'hAA, 32'd20, 1'b0, 1'b1));
    send_item(make_item(OP_CHECK, 32'h0, 8'h00, 32'h0, 1'b0, 1'b0));
    send_item(make_item(OP_CHECK, 32'h1, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0));
    // Upper verdict wins over the table contents.
    send_item(make_item(OP_CHECK, 32'h0, 8'h00, 32'h0, 1'b1, 1'b0));
    send_item(make_item(OP_CHECK, 32'h1, 8'h00, 32'h0, 1'b1, 1'b1));
    send_item(make_item(OP_CHECK, 32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, 1'b1));
    // Unused code with everything high and everything low.
    send_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_item(make_item(OP_UNUSED, 32'h0, 8'h00, 32'h0, 1'b0, 1'b0));
    // Entry seen at the top of time must survive: its expiry would wrap in 32 bits.
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_item(make_item(OP_CHECK, 32'h0, 8'h00, 32'h0, 1'b0, 1'b0));
    send_item(make_item(OP_ADD, 32'h8000_0001, 8'h01, 32'h7FFF_FFFF, 1'b1, 1'b1));
    send_item(make_item(OP_ADD, 32'hFFFF_FFFF, 8'h00, 32'h0, 1'b0, 1'b0));
    // Expiry boundary: equal to now stays, one past is removed.
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, DROP_PERIOD_RESET, 1'b0, 1'b0));
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, DROP_PERIOD_RESET + 1, 1'b0, 1'b0));
  endtask

  // Zero, all-ones and one-second drop periods.
  task automatic test_drop_period_extremes();
    wait_idle();
    write_drop_period('0);
    send_item(make_item(OP_ADD, 32'h0A00_0001, 8'h11, 32'd100, 1'b0, 1'b0));
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, 32'd100, 1'b0, 1'b0));
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, 32'd101, 1'b0, 1'b0));
    wait_idle();
    write_drop_period('1);
    send_item(make_item(OP_ADD, 32'h0A00_0002, 8'h22, 32'd0, 1'b0, 1'b0));
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0));
    wait_idle();
    write_drop_period(32'd1);
    send_item(make_item(OP_ADD, 32'h0A00_0003, 8'h44, 32'd50, 1'b0, 1'b0));
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, 32'd51, 1'b0, 1'b0));
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, 32'd52, 1'b0, 1'b0));
  endtask

  // Fill every slot, hit the full case, then age the whole table out at once.
  task automatic test_table_full();
    wait_idle();
    write_drop_period(32'd1000);
    // Clear out leftovers so the final sweep removes every slot.
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0));
    while (find_free_slot() >= 0) begin
      send_item(make_item(OP_ADD, $urandom, 8'($urandom_range(255)), 32'd5000,
                          1'($urandom_range(1)), 1'($urandom_range(1))));
    end
    send_item(make_item(OP_ADD, $urandom, 8'hFF, 32'd5100, 1'b0, 1'b0));
    // Refresh still works on a full table.
    send_item(make_item(OP_ADD, ban_addr[TABLE_DEPTH-1], 8'h80, 32'd5500, 1'b0, 1'b0));
    send_item(make_item(OP_CHECK, ban_addr[TABLE_DEPTH/2], 8'h00, 32'h0, 1'b0, 1'b0));
    send_item(make_item(OP_CHECK, $urandom, 8'h00, 32'h0, 1'b0, 1'b0));
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, 32'd6000, 1'b0, 1'b0));
    send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_item(make_item(OP_ADD, 32'hC0A8_0001, 8'h01, 32'd7000, 1'b0, 1'b0));
  endtask

  // Hold off the receiver for a long stretch while items keep coming,
  // so the output register fills and the input stalls.
  task automatic test_backpressure();
    wait_idle();
    stall_left = 2000;
    repeat (12) begin
      if ($urandom_range(3) == 0) begin
        send_item(make_item(OP_CLEANUP, 32'h0, 8'h00, clock_now, 1'b0, 1'b0));
      end else begin
        send_item(make_item(OP_CHECK, $urandom, 8'h00, clock_now, 1'b0,
                            1'($urandom_range(1))));
      end
    end
  endtask

  // Mostly well-formed traffic on a small address pool with a moving clock,
  // so adds refresh, checks hit and cleanups age entries out; some noise mixed in.
  task automatic test_random_traffic(input int unsigned count,
                                     input logic [TIME_W-1:0] period);
    logic [ADDR_W-1:0] pool [16];
    ibt_req_t          item;
    int unsigned       pick;
    int unsigned       step_max;
    wait_idle();
    write_drop_period(period);
    foreach (pool[i]) pool[i] = $urandom;
    step_max = period / 8 + 2;
    repeat (count) begin
      pick = $urandom_range(99);
      clock_now = clock_now + $urandom_range(step_max);
      item = make_item(OP_ADD, pool[$urandom_range(15)], 8'($urandom_range(255)),
                       clock_now, 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (pick < 15) item.addr = $urandom;
      if (pick < 45) begin
        item.op = OP_ADD;
      end else if (pick < 78) begin
        item.op              = OP_CHECK;
        item.upper_available = ($urandom_range(3) == 0);
      end else if (pick < 90) begin
        item.op = OP_CLEANUP;
      end else if (pick < 94) begin
        item.op = OP_UNUSED;
      end else begin
        // Noise: every field random, time included.
        item = make_item(op_t'($urandom_range(3)), $urandom, 8'($urandom_range(255)),
                         $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      send_item(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Drive every input to a known value and hold reset.
    rst                    <= 1'b1;
    in_bus.valid           <= 1'b0;
    in_bus.operation       <= OP_ADD;
    in_bus.ip_address      <= '0;
    in_bus.reason_flags    <= '0;
    in_bus.now_seconds     <= '0;
    in_bus.upper_available <= 1'b0;
    in_bus.upper_banned    <= 1'b0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.data           <= '0;
    foreach (ban_valid[i]) begin
      ban_valid[i] = 1'b0;
      ban_addr[i]  = '0;
      ban_flags[i] = '0;
      ban_seen[i]  = '0;
    end
    drop_period_model = DROP_PERIOD_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Sender mostly busy, receiver mostly stalled.
    set_idling(9, 83);
    test_directed();
    test_drop_period_extremes();
    test_table_full();
    test_random_traffic(70, $urandom_range(60, 5));

    // Sender mostly idle, receiver mostly ready.
    set_idling(83, 9);
    test_random_traffic(70, $urandom_range(200, 20));

    // No idling on either side.
    set_idling(0, 0);
    test_backpressure();
    test_random_traffic(70, DROP_PERIOD_RESET);

    // Drain, then allow a full scan for any stray result to show up.
    wait_idle();
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
